FILE: src/first_fit_heap_allocator_unit_assert.svh
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every rising clock edge outside reset.
`define FFHA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks that a condition never holds outside reset.
`define FFHA_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FFHA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFHA_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: src/ffha_pkg.sv
// Package with the types and constants of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;
  localparam int unsigned HEAP_BYTES_DEF   = 65536;
  localparam int unsigned HEADER_BYTES_DEF = 24;
  localparam logic [31:0] BASE_RESET       = 32'h0100_0000;
  localparam int unsigned ALIGN_ROUND      = 15;
  localparam int unsigned SPLIT_SLACK      = 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_OOM       = 2'd1;
  localparam logic [1:0] ST_FREED     = 2'd2;
  localparam logic [1:0] ST_IGNORED   = 2'd3;

  typedef struct packed {
    logic        op;
    logic [15:0] req_size;
    logic [31:0] free_addr;
  } in_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  status;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_NEXT  = 4'b0100,
    S_SPLIT = 4'b1000
  } state_t;
endpackage
`default_nettype wire

FILE: src/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator with coalescing.
//
//  channel | ports                          | transaction taken when
//  --------+--------------------------------+---------------------------
//  input   | start, busy, in_data           | start high and busy low
//  result  | out_valid, out_data            | out_valid high (one cycle)
//  config  | cfg_valid, cfg_ready, cfg_data | cfg_valid and cfg_ready high
//
// An allocate walks the block headers in S_WALK, then writes the tail header in
// S_SPLIT when the block is split; a free walks the headers, then folds in the
// following header in S_NEXT unless the freed block is the last one. The walk is
// bound by the single read port of the header memory, one header per cycle. A
// null free is answered from idle without a walk. The result appears the cycle
// after the last step. Reset is synchronous; after reset a flag stands in for the
// header at offset zero, so no clearing pass is needed. Headers are stored at their
// byte offset, so entries inside a block are never read. The receiver cannot stall.
`default_nettype none
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
#(
  parameter int unsigned HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_t         in_data,
  output logic             out_valid,
  output out_t             out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);
  `include "first_fit_heap_allocator_unit_assert.svh"

  // Block offsets are sums of header sizes and multiples of 16.
  localparam int unsigned GB = (HEADER_BYTES % 16 == 0) ? 4 :
                               (HEADER_BYTES % 8 == 0)  ? 3 :
                               (HEADER_BYTES % 4 == 0)  ? 2 :
                               (HEADER_BYTES % 2 == 0)  ? 1 : 0;
  localparam int unsigned DEPTH  = (HEAP_BYTES + (1 << GB) - 1) >> GB;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned OFF_W  = $clog2(HEAP_BYTES + 1);
  localparam int unsigned SIZE_W = $clog2(HEAP_BYTES);
  localparam int unsigned CW     = ((OFF_W > 17) ? OFF_W : 17) + 1;
  localparam logic [CW-1:0] HB_C    = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] HEAP_C  = CW'(HEAP_BYTES);
  localparam logic [CW-1:0] SLACK_C = CW'(SPLIT_SLACK);
  localparam logic [CW-1:0] ROUND_C = CW'(ALIGN_ROUND);
  localparam logic [SIZE_W:0] INIT_ENTRY = {1'b1, SIZE_W'(HEAP_BYTES - HEADER_BYTES)};

  // Header memory: free mark on top, payload size below.
  logic [SIZE_W:0] mem [DEPTH];
  logic [SIZE_W:0] rd_data_r;
  logic            init_hit_r;
  logic            rd_en, wr_en;
  logic [IDX_W-1:0] rd_idx, wr_idx;
  logic [SIZE_W:0] wr_data;

  state_t            state_r, state_nxt;
  logic              op_r, op_nxt;
  logic [CW-1:0]     need_r, need_nxt;
  logic [31:0]       faddr_r, faddr_nxt;
  logic [31:0]       base_r, base_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [OFF_W-1:0]  prev_off_r, prev_off_nxt;
  logic [SIZE_W-1:0] prev_size_r, prev_size_nxt;
  logic              prev_free_r, prev_free_nxt;
  logic [OFF_W-1:0]  merge_off_r, merge_off_nxt;
  logic [CW-1:0]     msize_r, msize_nxt;
  logic [OFF_W-1:0]  tail_off_r, tail_off_nxt;
  logic [SIZE_W-1:0] tail_size_r, tail_size_nxt;
  logic              init_r, init_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_addr_r, out_addr_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  // Values derived from the header that arrives this cycle.
  logic [SIZE_W:0] ent;
  logic [CW-1:0]   s_ext, off_ext, nxt_ext, merge_base, merge_total;
  logic            ent_free, at_end, fits, do_split;
  logic [31:0]     paddr;

  assign ent      = init_hit_r ? INIT_ENTRY : rd_data_r;
  assign ent_free = ent[SIZE_W];
  assign s_ext    = CW'(ent[SIZE_W-1:0]);
  assign off_ext  = CW'(off_r);
  assign nxt_ext  = off_ext + HB_C + s_ext;
  assign at_end   = nxt_ext >= HEAP_C;
  assign fits     = ent_free && (s_ext >= need_r);
  assign do_split = s_ext > (need_r + HB_C + SLACK_C);
  assign paddr    = base_r + 32'(off_r) + 32'(HEADER_BYTES);
  assign merge_base  = prev_free_r ? (CW'(prev_size_r) + HB_C + s_ext) : s_ext;
  assign merge_total = ent_free ? (msize_r + HB_C + s_ext) : msize_r;

  // Sequencer: walks the header chain and issues the write-back.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    need_nxt       = need_r;
    faddr_nxt      = faddr_r;
    base_nxt       = base_r;
    off_nxt        = off_r;
    prev_off_nxt   = prev_off_r;
    prev_size_nxt  = prev_size_r;
    prev_free_nxt  = prev_free_r;
    merge_off_nxt  = merge_off_r;
    msize_nxt      = msize_r;
    tail_off_nxt   = tail_off_r;
    tail_size_nxt  = tail_size_r;
    init_nxt       = init_r;
    out_valid_nxt  = 1'b0;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    rd_en   = 1'b0;
    rd_idx  = '0;
    wr_en   = 1'b0;
    wr_idx  = '0;
    wr_data = '0;

    if (cfg_valid && cfg_ready) begin
      base_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt        = in_data.op;
          need_nxt      = (CW'(in_data.req_size) + ROUND_C) & ~ROUND_C;
          faddr_nxt     = in_data.free_addr;
          off_nxt       = '0;
          prev_free_nxt = 1'b0;
          if (in_data.op == OP_FREE && in_data.free_addr == 32'd0) begin
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = 32'd0;
            out_status_nxt = ST_IGNORED;
          end else begin
            rd_en     = 1'b1;
            rd_idx    = '0;
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (op_r == OP_ALLOC && fits) begin
          wr_en  = 1'b1;
          wr_idx = IDX_W'(off_r >> GB);
          out_addr_nxt   = paddr;
          out_status_nxt = ST_ALLOCATED;
          if (do_split) begin
            wr_data       = {1'b0, need_r[SIZE_W-1:0]};
            tail_off_nxt  = OFF_W'(off_ext + HB_C + need_r);
            tail_size_nxt = SIZE_W'(s_ext - need_r - HB_C);
            state_nxt     = S_SPLIT;
          end else begin
            wr_data       = {1'b0, ent[SIZE_W-1:0]};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (op_r == OP_FREE && paddr == faddr_r) begin
          // Found the block: fold in a free predecessor, then look at the successor.
          merge_off_nxt = prev_free_r ? prev_off_r : off_r;
          msize_nxt     = merge_base;
          out_addr_nxt   = 32'd0;
          out_status_nxt = ST_FREED;
          if (at_end) begin
            wr_en         = 1'b1;
            wr_idx        = IDX_W'((prev_free_r ? prev_off_r : off_r) >> GB);
            wr_data       = {1'b1, merge_base[SIZE_W-1:0]};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_idx    = IDX_W'(nxt_ext[OFF_W-1:0] >> GB);
            off_nxt   = nxt_ext[OFF_W-1:0];
            state_nxt = S_NEXT;
          end
        end else if (at_end) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = 32'd0;
          out_status_nxt = (op_r == OP_ALLOC) ? ST_OOM : ST_IGNORED;
          state_nxt      = S_IDLE;
        end else begin
          prev_off_nxt  = off_r;
          prev_size_nxt = ent[SIZE_W-1:0];
          prev_free_nxt = ent_free;
          off_nxt       = nxt_ext[OFF_W-1:0];
          rd_en         = 1'b1;
          rd_idx        = IDX_W'(nxt_ext[OFF_W-1:0] >> GB);
        end
      end
      S_NEXT: begin
        // Fold in a free successor and write the merged header.
        wr_en         = 1'b1;
        wr_idx        = IDX_W'(merge_off_r >> GB);
        wr_data       = {1'b1, merge_total[SIZE_W-1:0]};
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SPLIT: begin
        wr_en         = 1'b1;
        wr_idx        = IDX_W'(tail_off_r >> GB);
        wr_data       = {1'b1, tail_size_r};
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (wr_en && wr_idx == '0) begin
      init_nxt = 1'b0;
    end
  end

  // Header memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r  <= mem[rd_idx];
      init_hit_r <= init_r && (rd_idx == '0);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
      base_r      <= BASE_RESET;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
      base_r      <= base_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    need_r       <= need_nxt;
    faddr_r      <= faddr_nxt;
    off_r        <= off_nxt;
    prev_off_r   <= prev_off_nxt;
    prev_size_r  <= prev_size_nxt;
    prev_free_r  <= prev_free_nxt;
    merge_off_r  <= merge_off_nxt;
    msize_r      <= msize_nxt;
    tail_off_r   <= tail_off_nxt;
    tail_size_r  <= tail_size_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = '{addr: out_addr_r, status: out_status_r};

  // A result only follows an accepted transaction or a walk in progress.
  `FFHA_ASSERT(a_result_origin, clk, rst_n, out_valid |-> $past(busy || start), "stray result")
  // An accepted transaction either starts a walk or answers at once.
  `FFHA_ASSERT(a_accept_moves, clk, rst_n, (start && !busy) |=> (busy || out_valid), "lost item")
  // Once the header at offset zero is written, the reset stand-in stays retired.
  `FFHA_ASSERT(a_init_once, clk, rst_n, !init_r |=> !init_r, "init flag came back")
  // An out-of-memory result always carries a null address.
  `FFHA_NEVER(a_oom_null, clk, rst_n, out_valid && out_data.status == ST_OOM && |out_data.addr, "oom addr")
endmodule
`default_nettype wire
